### sv/websocket_frame_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// websocket frame decoder assertion macros
// shared forms for the concurrent checks of the decoder
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// types and constants of the websocket frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } wsfd_phase_t;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // byte index of the final byte of each multi-byte header field
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

endpackage

`default_nettype wire

### sv/websocket_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder_unit
// receive-side websocket frame parser and payload unmasker, one byte a clock
// ----------------------------------------------------------------------------
// Takes the received stream one byte per request and parses each frame
// header: opcode from byte 0, mask flag and 7-bit length from byte 1, an
// optional 2-byte or 8-byte big-endian length, and an optional 4-byte key.
// Header bytes give no result, except the byte that completes the header of
// a zero-length frame, which gives one result flagged empty and last. Each
// payload byte gives one result, unmasked with key byte (index mod 4) when the mask flag is set and
// tagged with the opcode and a last-of-frame flag. FIN and RSV are ignored.
// Throughput is one byte per clock while the result is not stalled. The result
// of a byte passes through the input register, then is parsed into the result
// register. A stalled result holds the input register, and the input stalls in
// that same cycle. The 64-bit length decrement and zero test set the critical
// path of the parse stage.
`default_nettype none

`include "websocket_frame_decoder_unit_assert.svh"

module websocket_frame_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input byte stream
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // result stream
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_last_of_frame,
  output logic            out_empty_frame
);

  import wsfd_pkg::*;

  // input stage
  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;

  // parser state
  wsfd_phase_t phase_r,  phase_nxt;
  logic [2:0]  fcnt_r,   fcnt_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r,   mask_nxt;
  logic [63:0] rem_r,    rem_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [1:0]  kpos_r,   kpos_nxt;

  // result stage
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_opcode_r;
  logic        out_last_r;
  logic        out_empty_r;

  // parse results
  logic        out_free;
  logic        s1_fire;
  logic        len_done;
  logic        hdr_done;
  logic        res_vld;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        res_empty;
  logic [63:0] rem_dec;
  logic [7:0]  key_shift;

  // flow control: the input register moves whenever the result register is free
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // payload helpers: decremented length and selected key byte
  assign rem_dec   = rem_r - 64'd1;
  assign key_shift = 8'(key_r >> {~kpos_r, 3'b000});

  // parse one byte
  always_comb begin
    phase_nxt  = phase_r;
    fcnt_nxt   = fcnt_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    kpos_nxt   = kpos_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    res_vld    = 1'b0;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_empty  = 1'b0;

    unique case (phase_r)
      PH_HDR1: begin
        mask_nxt = s1_byte_r[7];
        fcnt_nxt = 3'd0;
        rem_nxt  = 64'd0;
        if (s1_byte_r[6:0] == LEN_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (s1_byte_r[6:0] == LEN_EXT64) begin
          phase_nxt = PH_EXT64;
        end else begin
          rem_nxt  = {57'd0, s1_byte_r[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT16: begin
        rem_nxt = {48'd0, rem_r[7:0], s1_byte_r};
        if (fcnt_r >= EXT16_LAST) begin
          len_done = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      PH_EXT64: begin
        rem_nxt = {rem_r[55:0], s1_byte_r};
        if (fcnt_r >= EXT64_LAST) begin
          len_done = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], s1_byte_r};
        if (fcnt_r >= KEY_LAST) begin
          hdr_done = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        res_vld  = 1'b1;
        res_byte = mask_r ? (s1_byte_r ^ key_shift) : s1_byte_r;
        kpos_nxt = kpos_r + 2'd1;
        rem_nxt  = rem_dec;
        res_last = (rem_dec == 64'd0);
        if (rem_dec == 64'd0) begin
          phase_nxt = PH_HDR0;
          kpos_nxt  = 2'd0;
        end
      end
      // first header byte, also taken for any unused phase code
      default: begin
        opcode_nxt = s1_byte_r[3:0];
        phase_nxt  = PH_HDR1;
        fcnt_nxt   = 3'd0;
      end
    endcase

    // length known: key next if masked, else header complete
    if (len_done) begin
      fcnt_nxt = 3'd0;
      if (mask_nxt) begin
        key_nxt   = 32'd0;
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: empty frame result or on to payload
    if (hdr_done) begin
      fcnt_nxt = 3'd0;
      kpos_nxt = 2'd0;
      if (rem_nxt == 64'd0) begin
        res_vld   = 1'b1;
        res_last  = 1'b1;
        res_empty = 1'b1;
        phase_nxt = PH_HDR0;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fcnt_r   <= 3'd0;
      opcode_r <= 4'd0;
      mask_r   <= 1'b0;
      rem_r    <= 64'd0;
      key_r    <= 32'd0;
      kpos_r   <= 2'd0;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      fcnt_r   <= fcnt_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      kpos_r   <= kpos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_vld) begin
      out_byte_r   <= res_byte;
      out_opcode_r <= opcode_r;
      out_last_r   <= res_last;
      out_empty_r  <= res_empty;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_frame_opcode  = out_opcode_r;
  assign out_last_of_frame = out_last_r;
  assign out_empty_frame   = out_empty_r;

  // checks
  `WSFD_ASSERT_NOW(a_empty_is_last, out_valid_r && out_empty_r,
    out_last_r && (out_byte_r == 8'd0), "empty frame result not last or not zero")
  `WSFD_ASSERT_NOW(a_payload_len, phase_r == PH_PAYLOAD, rem_r != 64'd0,
    "payload phase with zero remaining length")
  `WSFD_ASSERT_NOW(a_key_masked, phase_r == PH_KEY, mask_r,
    "key phase on an unmasked frame")
  `WSFD_ASSERT_NEXT(a_result_lands, s1_fire && res_vld, out_valid_r,
    "parsed result not held in the result register")

endmodule

`default_nettype wire
